[rtl/dqa_pkg.sv]
// shared op codes, item classes and queue sizing for the dual quaternion alu
`default_nettype none

package dqa_pkg;

  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_CONJ = 3'd3;
  localparam logic [2:0] OP_DOT  = 3'd4;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_MUL,
    CLS_ADD,
    CLS_SUB,
    CLS_CONJ,
    CLS_DOT
  } op_class_e;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

[rtl/dqa_front.sv]
// front end: accepts requests, classifies the op, unpacks parts and queues them
`default_nettype none

module dqa_front #(
  parameter int PART_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [2:0]                  op_i,
  input  wire logic [3:0][63:0]            a_i,
  input  wire logic [3:0][63:0]            b_i,
  output logic                             q_valid_o,
  input  wire logic                        q_ready_i,
  output dqa_pkg::op_class_e               cls_o,
  output logic [3:0][PART_WIDTH-1:0]       a_re_o,
  output logic [3:0][PART_WIDTH-1:0]       a_du_o,
  output logic [3:0][PART_WIDTH-1:0]       b_re_o,
  output logic [3:0][PART_WIDTH-1:0]       b_du_o
);
  import dqa_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    op_class_e                   cls;
    logic [3:0][PART_WIDTH-1:0]  a_re;
    logic [3:0][PART_WIDTH-1:0]  a_du;
    logic [3:0][PART_WIDTH-1:0]  b_re;
    logic [3:0][PART_WIDTH-1:0]  b_du;
  } item_t;

  item_t          item_in;
  item_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           push, pop;

  always_comb begin
    case (op_i)
      OP_MUL:  item_in.cls = CLS_MUL;
      OP_ADD:  item_in.cls = CLS_ADD;
      OP_SUB:  item_in.cls = CLS_SUB;
      OP_CONJ: item_in.cls = CLS_CONJ;
      OP_DOT:  item_in.cls = CLS_DOT;
      default: item_in.cls = CLS_ZERO;
    endcase
    // bits of each 32-bit half above the part width are dropped
    for (int i = 0; i < 4; i++) begin
      item_in.a_re[i] = a_i[i][32+PART_WIDTH-1:32];
      item_in.a_du[i] = a_i[i][PART_WIDTH-1:0];
      item_in.b_re[i] = b_i[i][32+PART_WIDTH-1:32];
      item_in.b_du[i] = b_i[i][PART_WIDTH-1:0];
    end
  end

  assign in_ready_o = (count_q != CW'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign cls_o  = mem_q[rd_ptr_q].cls;
  assign a_re_o = mem_q[rd_ptr_q].a_re;
  assign a_du_o = mem_q[rd_ptr_q].a_du;
  assign b_re_o = mem_q[rd_ptr_q].b_re;
  assign b_du_o = mem_q[rd_ptr_q].b_du;

endmodule

`default_nettype wire

[rtl/dqa_back.sv]
// back end: multiply, shift, combine and saturate pipeline with output register
`default_nettype none

module dqa_back #(
  parameter int PART_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  output logic                             q_ready_o,
  input  wire dqa_pkg::op_class_e          cls_i,
  input  wire logic [3:0][PART_WIDTH-1:0]  a_re_i,
  input  wire logic [3:0][PART_WIDTH-1:0]  a_du_i,
  input  wire logic [3:0][PART_WIDTH-1:0]  b_re_i,
  input  wire logic [3:0][PART_WIDTH-1:0]  b_du_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [3:0][63:0]                 r_o,
  output logic                             saturated_o
);
  import dqa_pkg::*;

  localparam int W  = PART_WIDTH;
  localparam int MW = 2 * W;
  localparam int PW = MW - FRAC_BITS;
  localparam int LW = W + 1;
  localparam int AW = (PW + 3 > W + 2) ? PW + 3 : W + 2;
  localparam logic signed [AW-1:0] SAT_MAX = {{(AW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN = {{(AW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic signed [W-1:0]  a_re [4], a_du [4], b_re [4], b_du [4];
  logic signed [LW-1:0] lin_re [4], lin_du [4];

  op_class_e            cls1_q, cls2_q, cls3_q;
  logic signed [MW-1:0] p_rr_q [4][4], p_rd_q [4][4], p_dr_q [4][4];
  logic signed [LW-1:0] lin1_re_q [4], lin1_du_q [4];
  logic signed [PW-1:0] d_re_q [4][4];
  logic signed [PW:0]   d_du_q [4][4];
  logic signed [LW-1:0] lin2_re_q [4], lin2_du_q [4];
  logic signed [AW-1:0] e_re [4][4], e_du [4][4];
  logic signed [AW-1:0] acc_re_d [4], acc_du_d [4];
  logic signed [AW-1:0] acc_re_q [4], acc_du_q [4];
  logic signed [W-1:0]  res_re_d [4], res_du_d [4];
  logic signed [W-1:0]  res_re_q [4], res_du_q [4];
  logic                 sat_d, sat_q;

  // the whole pipeline holds while a finished result waits
  assign adv       = ~(out_valid_o & ~out_ready_i);
  assign q_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_o <= v3_q;
    end
  end

  // stage 1: part products and the linear ops
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_re[i] = signed'(a_re_i[i]);
      a_du[i] = signed'(a_du_i[i]);
      b_re[i] = signed'(b_re_i[i]);
      b_du[i] = signed'(b_du_i[i]);
    end
    for (int i = 0; i < 4; i++) begin
      case (cls_i)
        CLS_ADD: begin
          lin_re[i] = LW'(a_re[i]) + LW'(b_re[i]);
          lin_du[i] = LW'(a_du[i]) + LW'(b_du[i]);
        end
        CLS_SUB: begin
          lin_re[i] = LW'(a_re[i]) - LW'(b_re[i]);
          lin_du[i] = LW'(a_du[i]) - LW'(b_du[i]);
        end
        CLS_CONJ: begin
          // scalar w keeps its sign
          if (i == 3) begin
            lin_re[i] = LW'(a_re[i]);
            lin_du[i] = LW'(a_du[i]);
          end else begin
            lin_re[i] = -LW'(a_re[i]);
            lin_du[i] = -LW'(a_du[i]);
          end
        end
        default: begin
          lin_re[i] = '0;
          lin_du[i] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls1_q <= cls_i;
      for (int i = 0; i < 4; i++) begin
        lin1_re_q[i] <= lin_re[i];
        lin1_du_q[i] <= lin_du[i];
        for (int j = 0; j < 4; j++) begin
          p_rr_q[i][j] <= a_re[i] * b_re[j];
          p_rd_q[i][j] <= a_re[i] * b_du[j];
          p_dr_q[i][j] <= a_du[i] * b_re[j];
        end
      end
    end
  end

  // stage 2: floor shift, dual part sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls2_q <= cls1_q;
      for (int i = 0; i < 4; i++) begin
        lin2_re_q[i] <= lin1_re_q[i];
        lin2_du_q[i] <= lin1_du_q[i];
        for (int j = 0; j < 4; j++) begin
          d_re_q[i][j] <= signed'(p_rr_q[i][j][MW-1:FRAC_BITS]);
          d_du_q[i][j] <= (PW+1)'(signed'(p_rd_q[i][j][MW-1:FRAC_BITS]))
                        + (PW+1)'(signed'(p_dr_q[i][j][MW-1:FRAC_BITS]));
        end
      end
    end
  end

  // stage 3: hamilton combine, dot sum or linear pass
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e_re[i][j] = AW'(d_re_q[i][j]);
        e_du[i][j] = AW'(d_du_q[i][j]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      acc_re_d[k] = '0;
      acc_du_d[k] = '0;
    end
    case (cls2_q)
      CLS_MUL: begin
        acc_re_d[0] = e_re[3][0] + e_re[0][3] + e_re[1][2] - e_re[2][1];
        acc_du_d[0] = e_du[3][0] + e_du[0][3] + e_du[1][2] - e_du[2][1];
        acc_re_d[1] = e_re[3][1] + e_re[1][3] + e_re[2][0] - e_re[0][2];
        acc_du_d[1] = e_du[3][1] + e_du[1][3] + e_du[2][0] - e_du[0][2];
        acc_re_d[2] = e_re[3][2] + e_re[2][3] + e_re[0][1] - e_re[1][0];
        acc_du_d[2] = e_du[3][2] + e_du[2][3] + e_du[0][1] - e_du[1][0];
        acc_re_d[3] = e_re[3][3] - e_re[0][0] - e_re[1][1] - e_re[2][2];
        acc_du_d[3] = e_du[3][3] - e_du[0][0] - e_du[1][1] - e_du[2][2];
      end
      CLS_DOT: begin
        acc_re_d[0] = e_re[0][0] + e_re[1][1] + e_re[2][2] + e_re[3][3];
        acc_du_d[0] = e_du[0][0] + e_du[1][1] + e_du[2][2] + e_du[3][3];
      end
      CLS_ADD, CLS_SUB, CLS_CONJ: begin
        for (int k = 0; k < 4; k++) begin
          acc_re_d[k] = AW'(lin2_re_q[k]);
          acc_du_d[k] = AW'(lin2_du_q[k]);
        end
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          acc_re_d[k] = '0;
          acc_du_d[k] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls3_q <= cls2_q;
      for (int k = 0; k < 4; k++) begin
        acc_re_q[k] <= acc_re_d[k];
        acc_du_q[k] <= acc_du_d[k];
      end
    end
  end

  // stage 4: clamp into the output register
  always_comb begin
    sat_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (acc_re_q[k] > SAT_MAX) begin
        res_re_d[k] = W'(SAT_MAX);
        sat_d       = 1'b1;
      end else if (acc_re_q[k] < SAT_MIN) begin
        res_re_d[k] = W'(SAT_MIN);
        sat_d       = 1'b1;
      end else begin
        res_re_d[k] = W'(acc_re_q[k]);
      end
      if (acc_du_q[k] > SAT_MAX) begin
        res_du_d[k] = W'(SAT_MAX);
        sat_d       = 1'b1;
      end else if (acc_du_q[k] < SAT_MIN) begin
        res_du_d[k] = W'(SAT_MIN);
        sat_d       = 1'b1;
      end else begin
        res_du_d[k] = W'(acc_du_q[k]);
      end
    end
    // unused op codes never clamp
    if (cls3_q == CLS_ZERO) begin
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sat_q <= sat_d;
      for (int k = 0; k < 4; k++) begin
        res_re_q[k] <= res_re_d[k];
        res_du_q[k] <= res_du_d[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r_o[k] = {32'(res_re_q[k]), 32'(res_du_q[k])};
    end
  end

  assign saturated_o = sat_q;

endmodule

`default_nettype wire

[rtl/dual_quaternion_alu.sv]
// top level of the fixed-point dual quaternion alu
//
// usage: a request carries an op code and two dual quaternions a and b,
// each component a 64-bit word with the real part in the upper half and
// the dual part in the lower half, both signed fixed point. the result
// channel returns r_x..r_w and a saturated flag, one result per request,
// in request order. ops: hamilton product, add, subtract, conjugate of a,
// and dot product in r_x; other codes give all zeros.
// both channels are valid/ready. a request is taken whenever the four
// entry front queue has room, one per cycle, also while a result waits.
// a request is written into the queue at the edge that takes it, then
// passes the product stage (48 part multipliers), the floor-shift stage,
// the combine stage and the clamp into the output register, each stage
// registered, before result valid rises. sustained
// throughput is one request per cycle when the receiver keeps ready high.
// when the receiver stalls the back pipeline holds as a whole and the
// queue keeps taking requests until it is full, then in_ready_o drops.
// reset empties the queue and clears every pipeline valid bit.
`default_nettype none

module dual_quaternion_alu #(
  parameter int PART_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [63:0] a_x_i,
  input  wire logic [63:0] a_y_i,
  input  wire logic [63:0] a_z_i,
  input  wire logic [63:0] a_w_i,
  input  wire logic [63:0] b_x_i,
  input  wire logic [63:0] b_y_i,
  input  wire logic [63:0] b_z_i,
  input  wire logic [63:0] b_w_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      r_x_o,
  output logic [63:0]      r_y_o,
  output logic [63:0]      r_z_o,
  output logic [63:0]      r_w_o,
  output logic             saturated_o
);
  import dqa_pkg::*;

  logic [3:0][63:0]            a_all, b_all, r_all;
  logic                        q_valid, q_ready;
  op_class_e                   q_cls;
  logic [3:0][PART_WIDTH-1:0]  q_a_re, q_a_du, q_b_re, q_b_du;

  assign a_all = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign b_all = {b_w_i, b_z_i, b_y_i, b_x_i};

  dqa_front #(
    .PART_WIDTH (PART_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .a_i        (a_all),
    .b_i        (b_all),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .cls_o      (q_cls),
    .a_re_o     (q_a_re),
    .a_du_o     (q_a_du),
    .b_re_o     (q_b_re),
    .b_du_o     (q_b_du)
  );

  dqa_back #(
    .PART_WIDTH (PART_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .cls_i       (q_cls),
    .a_re_i      (q_a_re),
    .a_du_i      (q_a_du),
    .b_re_i      (q_b_re),
    .b_du_i      (q_b_du),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .r_o         (r_all),
    .saturated_o (saturated_o)
  );

  assign r_x_o = r_all[0];
  assign r_y_o = r_all[1];
  assign r_z_o = r_all[2];
  assign r_w_o = r_all[3];

endmodule

`default_nettype wire

[rtl/dqa_checker.sv]
// port-level checks for the dual quaternion alu, bound to the top level
`default_nettype none

module dqa_checker #(
  parameter int PART_WIDTH = 32
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] r_x_o,
  input wire logic [63:0] r_y_o,
  input wire logic [63:0] r_z_o,
  input wire logic [63:0] r_w_o,
  input wire logic        saturated_o
);

  localparam logic [PART_WIDTH-1:0] P_MAX = {1'b0, {(PART_WIDTH - 1){1'b1}}};
  localparam logic [PART_WIDTH-1:0] P_MIN = {1'b1, {(PART_WIDTH - 1){1'b0}}};

  logic [7:0][31:0] halves;
  logic             all_ext;
  logic             any_limit;

  assign halves = {r_w_o, r_z_o, r_y_o, r_x_o};

  always_comb begin
    all_ext   = 1'b1;
    any_limit = 1'b0;
    for (int h = 0; h < 8; h++) begin
      if (halves[h] != 32'(signed'(halves[h][PART_WIDTH-1:0]))) begin
        all_ext = 1'b0;
      end
      if (halves[h][PART_WIDTH-1:0] == P_MAX || halves[h][PART_WIDTH-1:0] == P_MIN) begin
        any_limit = 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(r_x_o) && $stable(r_y_o)
      && $stable(r_z_o) && $stable(r_w_o) && $stable(saturated_o))
    else $error("stalled result changed");

  a_sign_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> all_ext)
    else $error("result part not sign-extended to its half");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> any_limit)
    else $error("saturated set but no part at a limit");

endmodule

bind dual_quaternion_alu dqa_checker #(.PART_WIDTH(PART_WIDTH)) u_dqa_checker (.*);

`default_nettype wire

[sim/dqa_checker.sv]
// request/result monitor, dual quaternion predictor and scoreboard for the alu
module dqa_scoreboard #(
  parameter int PART_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic [2:0]       op_i,
  input  wire logic [3:0][63:0] a_i,
  input  wire logic [3:0][63:0] b_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic [3:0][63:0] r_i,
  input  wire logic             saturated_i,
  output int                    mismatches_o,
  output int                    pending_o
);
  import dqa_pkg::*;

  localparam int X = 0;
  localparam int Y = 1;
  localparam int Z = 2;
  localparam int W = 3;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    longint re;
    longint du;
  } dual_t;

  typedef struct packed {
    logic [3:0][63:0] comp;
    logic             sat;
  } dq_result_t;

  dq_result_t awaited_results[$];
  int         mismatch_count = 0;
  int         results_seen = 0;
  int         pending_count = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  function automatic longint part_value(logic [31:0] half);
    logic [PART_WIDTH-1:0] bits;
    bits = half[PART_WIDTH-1:0];
    return longint'($signed(bits));
  endfunction

  function automatic dual_t unpack_dual(logic [63:0] word);
    dual_t d;
    d.re = part_value(word[63:32]);
    d.du = part_value(word[31:0]);
    return d;
  endfunction

  // exact product, arithmetic shift floors toward minus infinity
  function automatic longint fixed_mul(longint x, longint y);
    longint prod;
    prod = x * y;
    return prod >>> FRAC_BITS;
  endfunction

  function automatic dual_t dual_mul(dual_t p, dual_t q);
    dual_t d;
    d.re = fixed_mul(p.re, q.re);
    d.du = fixed_mul(p.re, q.du) + fixed_mul(p.du, q.re);
    return d;
  endfunction

  function automatic dual_t dual_add(dual_t p, dual_t q);
    dual_t d;
    d.re = p.re + q.re;
    d.du = p.du + q.du;
    return d;
  endfunction

  function automatic dual_t dual_sub(dual_t p, dual_t q);
    dual_t d;
    d.re = p.re - q.re;
    d.du = p.du - q.du;
    return d;
  endfunction

  function automatic logic [31:0] clip_part(longint v, inout logic clipped);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (PART_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clipped = 1'b1;
      v = hi;
    end else if (v < lo) begin
      clipped = 1'b1;
      v = lo;
    end
    return v[31:0];
  endfunction

  function automatic dq_result_t predict_dq(logic [2:0] op, logic [3:0][63:0] aw,
                                            logic [3:0][63:0] bw);
    dual_t      a[4];
    dual_t      b[4];
    dual_t      r[4];
    dual_t      zero;
    dq_result_t res;
    logic       clipped;
    zero.re = 0;
    zero.du = 0;
    clipped = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = unpack_dual(aw[i]);
      b[i] = unpack_dual(bw[i]);
      r[i] = zero;
    end
    case (op)
      OP_MUL: begin
        r[X] = dual_sub(dual_add(dual_add(dual_mul(a[W], b[X]), dual_mul(a[X], b[W])),
                                 dual_mul(a[Y], b[Z])), dual_mul(a[Z], b[Y]));
        r[Y] = dual_sub(dual_add(dual_add(dual_mul(a[W], b[Y]), dual_mul(a[Y], b[W])),
                                 dual_mul(a[Z], b[X])), dual_mul(a[X], b[Z]));
        r[Z] = dual_sub(dual_add(dual_add(dual_mul(a[W], b[Z]), dual_mul(a[Z], b[W])),
                                 dual_mul(a[X], b[Y])), dual_mul(a[Y], b[X]));
        r[W] = dual_sub(dual_sub(dual_sub(dual_mul(a[W], b[W]), dual_mul(a[X], b[X])),
                                 dual_mul(a[Y], b[Y])), dual_mul(a[Z], b[Z]));
      end
      OP_ADD: begin
        for (int i = 0; i < 4; i++) r[i] = dual_add(a[i], b[i]);
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) r[i] = dual_sub(a[i], b[i]);
      end
      OP_CONJ: begin
        for (int i = X; i <= Z; i++) r[i] = dual_sub(zero, a[i]);
        r[W] = a[W];
      end
      OP_DOT: begin
        for (int i = 0; i < 4; i++) r[X] = dual_add(r[X], dual_mul(a[i], b[i]));
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      res.comp[i] = {clip_part(r[i].re, clipped), clip_part(r[i].du, clipped)};
    end
    res.sat = clipped;
    return res;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    dq_result_t got;
    dq_result_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got.comp = r_i;
        got.sat  = saturated_i;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result %0d: x %h y %h z %h w %h sat %b", results_seen,
                     r_i[X], r_i[Y], r_i[Z], r_i[W], saturated_i);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected x %h y %h z %h w %h sat %b", want.comp[X], want.comp[Y],
                       want.comp[Z], want.comp[W], want.sat);
              $display("  actual   x %h y %h z %h w %h sat %b", got.comp[X], got.comp[Y],
                       got.comp[Z], got.comp[W], got.sat);
            end
          end
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(predict_dq(op_i, a_i, b_i));
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

[sim/tb_dual_quaternion_alu.sv]
// stimulus, handshake timing and verdict for the dual quaternion alu
module tb_dual_quaternion_alu;
  import dqa_pkg::*;

  localparam int RANDOM_REQUESTS = 1880;
  localparam int CALM_REQUESTS   = 300;
  localparam int IDLE_LIMIT      = 1000;
  localparam int DRAIN_CYCLES    = 10;

  localparam logic [63:0] MAX_WORD  = 64'h7FFF_FFFF_7FFF_FFFF;
  localparam logic [63:0] MIN_WORD  = 64'h8000_0000_8000_0000;
  localparam logic [63:0] MINUS_LSB = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PLUS_LSB  = 64'h0000_0001_0000_0001;
  localparam logic [63:0] ONE_REAL  = 64'h0001_0000_0000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic [63:0] a_x, a_y, a_z, a_w;
  logic [63:0] b_x, b_y, b_z, b_w;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] r_x, r_y, r_z, r_w;
  logic        saturated;
  bit          calm;
  int          mismatches;
  int          outstanding;

  logic [2:0] op_codes[5] = '{OP_MUL, OP_ADD, OP_SUB, OP_CONJ, OP_DOT};

  dual_quaternion_alu dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .a_x_i       (a_x),
    .a_y_i       (a_y),
    .a_z_i       (a_z),
    .a_w_i       (a_w),
    .b_x_i       (b_x),
    .b_y_i       (b_y),
    .b_z_i       (b_z),
    .b_w_i       (b_w),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .r_x_o       (r_x),
    .r_y_o       (r_y),
    .r_z_o       (r_z),
    .r_w_o       (r_w),
    .saturated_o (saturated)
  );

  dqa_scoreboard u_scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op),
    .a_i          ({a_w, a_z, a_y, a_x}),
    .b_i          ({b_w, b_z, b_y, b_x}),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .r_i          ({r_w, r_z, r_y, r_x}),
    .saturated_i  (saturated),
    .mismatches_o (mismatches),
    .pending_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly small fixed point values, some full range words and edge values
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2: return $urandom();
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {rand_part(), rand_part()};
  endfunction

  task automatic issue_request(input logic [2:0] code, input logic [3:0][63:0] a,
                               input logic [3:0][63:0] b);
    @(negedge clk);
    in_valid = 1'b1;
    op = code;
    {a_w, a_z, a_y, a_x} = a;
    {b_w, b_z, b_y, b_x} = b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // result side stalls in bursts until the final stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("dual_quaternion_alu verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [3:0][63:0] a;
    logic [3:0][63:0] b;
    logic [2:0]       code;
    int               phase;
    calm     = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    op       = OP_MUL;
    {a_w, a_z, a_y, a_x} = '0;
    {b_w, b_z, b_y, b_x} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all zero operands
    issue_request(OP_MUL, '0, '0);
    // every op against largest, most negative, one-lsb and identity operands
    for (int pat = 0; pat < 4; pat++) begin
      for (int k = 0; k < 5; k++) begin
        case (pat)
          0: begin
            a = {4{MAX_WORD}};
            b = {4{MAX_WORD}};
          end
          1: begin
            a = {4{MIN_WORD}};
            b = {4{MAX_WORD}};
          end
          2: begin
            // negative products must floor, not truncate toward zero
            a = {4{MINUS_LSB}};
            b = {4{PLUS_LSB}};
          end
          default: begin
            for (int i = 0; i < 4; i++) a[i] = rand_word();
            b = {ONE_REAL, 64'h0, 64'h0, 64'h0};
          end
        endcase
        issue_request(op_codes[k], a, b);
      end
    end
    // unused op codes give all zeros
    for (int k = 1; k <= 3; k++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = MAX_WORD ^ rand_word();
        b[i] = MIN_WORD ^ rand_word();
      end
      issue_request(OP_DOT + 3'(k), a, b);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - CALM_REQUESTS) calm = 1'b1;
      phase = (n / 80) % 3;
      if (!calm && ((phase == 1 && $urandom_range(0, 2) == 0) ||
                    (phase == 2 && $urandom_range(0, 7) == 0))) begin
        hold_off($urandom_range(1, 7));
      end
      for (int i = 0; i < 4; i++) begin
        a[i] = rand_word();
        b[i] = rand_word();
      end
      if ($urandom_range(0, 19) == 0) code = OP_DOT + 3'($urandom_range(1, 3));
      else code = op_codes[$urandom_range(0, 4)];
      issue_request(code, a, b);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("dual_quaternion_alu verification clean");
    end else begin
      $display("dual_quaternion_alu verification failed");
    end
    $finish;
  end

endmodule
